/* design/tolerance_vertex_merge_top_defines.svh */
// Assertion helpers for the checker file vtm_checker.sv.
`ifndef TOLERANCE_VERTEX_MERGE_TOP_DEFINES_SVH
`define TOLERANCE_VERTEX_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VTM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/vtm_pkg.sv */
`timescale 1ns / 1ps

package vtm_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int POS_W      = 32;
	localparam int IDX_W      = $clog2(MAX_NODES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int OUT_IDX_W  = 10;
	localparam int TOL_W      = 31;
	localparam int TOL_SQ_W   = 2 * TOL_W;
	localparam int SQ_W       = 2 * POS_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int NODE_W     = 3 * POS_W;

	typedef enum logic [1:0] {
		ST_MATCH = 2'd0,
		ST_NEW   = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic              accept;
		logic              issue;
		logic [IDX_W-1:0]  rd_addr;
		logic              flush;
		logic              set_res;
		logic [IDX_W-1:0]  res_idx;
		status_t           res_status;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic              busy;
		logic              out_free;
	} stat_t;

endpackage

/* design/vtm_ifs.sv */
`timescale 1ns / 1ps

interface vtm_in_if;
	logic                                valid;
	logic                                ready;
	logic                                start_mesh;
	logic signed [vtm_pkg::POS_W-1:0]    pos_x;
	logic signed [vtm_pkg::POS_W-1:0]    pos_y;
	logic signed [vtm_pkg::POS_W-1:0]    pos_z;

	modport source (output valid, start_mesh, pos_x, pos_y, pos_z, input ready);
	modport sink   (input valid, start_mesh, pos_x, pos_y, pos_z, output ready);
	modport mon    (input valid, ready, start_mesh, pos_x, pos_y, pos_z);
endinterface

interface vtm_out_if;
	logic                                valid;
	logic                                ready;
	logic [vtm_pkg::OUT_IDX_W-1:0]       node_index;
	logic [1:0]                          status;

	modport source (output valid, node_index, status, input ready);
	modport sink   (input valid, node_index, status, output ready);
	modport mon    (input valid, ready, node_index, status);
endinterface

/* design/tolerance_vertex_merge_top.sv */
// One request is handled at a time: a new request is taken only once the previous
// result has been loaded into the output register. The node memory has a single
// read port, so the scan reads one node per cycle, then five pipeline stages
// (read, difference, square, sum, compare) follow; the lowest matching index wins.
// Reset: node table empty, tolerance 1, no result pending; memory is not cleared.
`timescale 1ns / 1ps

module tolerance_vertex_merge_top (
	input  logic                            clk,
	input  logic                            arst_n,
	vtm_in_if.sink                          point,
	vtm_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [vtm_pkg::TOL_W-1:0]       cfg_wdata
);

	vtm_pkg::cmd_t  cmd;
	vtm_pkg::stat_t stat;

	vtm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (point.valid),
		.start_mesh (point.start_mesh),
		.in_ready   (point.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	vtm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.pos_x      (point.pos_x),
		.pos_y      (point.pos_y),
		.pos_z      (point.pos_z),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.node_index (result.node_index),
		.status     (result.status)
	);

endmodule

/* design/vtm_ram.sv */
`timescale 1ns / 1ps

module vtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/vtm_ctrl.sv */
`timescale 1ns / 1ps

module vtm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           start_mesh,
	output logic           in_ready,
	input  vtm_pkg::stat_t stat,
	output vtm_pkg::cmd_t  cmd
);

	vtm_pkg::state_t               state_q, state_d;
	logic [vtm_pkg::CNT_W-1:0]     scan_q;
	logic [vtm_pkg::CNT_W-1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.accept) begin
				scan_q <= '0;
				if (start_mesh) begin
					count_q <= '0;
				end
			end else if (cmd.issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.wr_en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			vtm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = vtm_pkg::S_SCAN;
				end
			end
			vtm_pkg::S_SCAN: begin
				// hits leave the pipe in index order, so the first one is the lowest
				priority if (stat.hit) begin
					cmd.flush      = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_idx    = stat.hit_idx;
					cmd.res_status = vtm_pkg::ST_MATCH;
					state_d        = vtm_pkg::S_RESP;
				end else if (scan_q < count_q) begin
					cmd.issue   = 1'b1;
					cmd.rd_addr = scan_q[vtm_pkg::IDX_W-1:0];
				end else if (!stat.busy) begin
					cmd.set_res = 1'b1;
					if (count_q < vtm_pkg::CNT_W'(vtm_pkg::MAX_NODES)) begin
						cmd.wr_en      = 1'b1;
						cmd.wr_addr    = count_q[vtm_pkg::IDX_W-1:0];
						cmd.res_idx    = count_q[vtm_pkg::IDX_W-1:0];
						cmd.res_status = vtm_pkg::ST_NEW;
					end else begin
						cmd.res_idx    = '0;
						cmd.res_status = vtm_pkg::ST_FULL;
					end
					state_d = vtm_pkg::S_RESP;
				end
			end
			vtm_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = vtm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = vtm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* design/vtm_dp.sv */
`timescale 1ns / 1ps

module vtm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vtm_pkg::cmd_t                       cmd,
	output vtm_pkg::stat_t                      stat,
	input  logic signed [vtm_pkg::POS_W-1:0]    pos_x,
	input  logic signed [vtm_pkg::POS_W-1:0]    pos_y,
	input  logic signed [vtm_pkg::POS_W-1:0]    pos_z,
	input  logic                                cfg_we,
	input  logic [vtm_pkg::TOL_W-1:0]           cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vtm_pkg::OUT_IDX_W-1:0]       node_index,
	output logic [1:0]                          status
);

	localparam int PW = vtm_pkg::POS_W;
	localparam int IW = vtm_pkg::IDX_W;

	function automatic logic [PW-1:0] abs_diff(input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b);
		logic signed [PW:0] d;
		d = {a[PW-1], a} - {b[PW-1], b};
		// |a-b| < 2^PW, so the low bits hold it exactly
		abs_diff = d[PW] ? PW'(-d) : d[PW-1:0];
	endfunction

	logic [vtm_pkg::TOL_W-1:0]     tol_q;
	logic [vtm_pkg::TOL_SQ_W-1:0]  tol_sq_q;
	logic signed [PW-1:0]          px_q, py_q, pz_q;

	logic [vtm_pkg::NODE_W-1:0]    rdata;
	logic signed [PW-1:0]          nx, ny, nz;

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IW-1:0]                 idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [PW-1:0]                 dx_s2, dy_s2, dz_s2;
	logic [vtm_pkg::SQ_W-1:0]      sqx_s3, sqy_s3, sqz_s3;
	logic [vtm_pkg::SUM_W-1:0]     sum_s4;
	logic                          hit_s5;

	logic [IW-1:0]                 res_idx_q;
	vtm_pkg::status_t              res_status_q;
	logic                          out_valid_q;
	logic [vtm_pkg::OUT_IDX_W-1:0] node_index_q;
	logic [1:0]                    status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= vtm_pkg::TOL_W'(1);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q     <= pos_x;
			py_q     <= pos_y;
			pz_q     <= pos_z;
			tol_sq_q <= vtm_pkg::TOL_SQ_W'(tol_q) * vtm_pkg::TOL_SQ_W'(tol_q);
		end
	end

	vtm_ram #(
		.WIDTH (vtm_pkg::NODE_W),
		.DEPTH (vtm_pkg::MAX_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (cmd.wr_addr),
		.wdata ({px_q, py_q, pz_q}),
		.re    (cmd.issue),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	assign nx = rdata[3*PW-1:2*PW];
	assign ny = rdata[2*PW-1:PW];
	assign nz = rdata[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (cmd.flush) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.rd_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
		dx_s2  <= abs_diff(px_q, nx);
		dy_s2  <= abs_diff(py_q, ny);
		dz_s2  <= abs_diff(pz_q, nz);
		sqx_s3 <= vtm_pkg::SQ_W'(dx_s2) * vtm_pkg::SQ_W'(dx_s2);
		sqy_s3 <= vtm_pkg::SQ_W'(dy_s2) * vtm_pkg::SQ_W'(dy_s2);
		sqz_s3 <= vtm_pkg::SQ_W'(dz_s2) * vtm_pkg::SQ_W'(dz_s2);
		sum_s4 <= vtm_pkg::SUM_W'(sqx_s3) + vtm_pkg::SUM_W'(sqy_s3)
			+ vtm_pkg::SUM_W'(sqz_s3);
		hit_s5 <= (sum_s4 <= vtm_pkg::SUM_W'(tol_sq_q));
	end

	assign stat.hit      = v_s5 && hit_s5;
	assign stat.hit_idx  = idx_s5;
	assign stat.busy     = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_idx_q    <= cmd.res_idx;
			res_status_q <= cmd.res_status;
		end
		if (cmd.load_out) begin
			node_index_q <= vtm_pkg::OUT_IDX_W'(res_idx_q);
			status_q     <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign node_index = node_index_q;
	assign status     = status_q;

endmodule

/* design/vtm_checker.sv */
`timescale 1ns / 1ps
`include "tolerance_vertex_merge_top_defines.svh"

module vtm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [vtm_pkg::OUT_IDX_W-1:0] node_index,
	input logic [1:0]                    status
);

	localparam logic [1:0] FULL = vtm_pkg::ST_FULL;

	logic res_full;
	logic stall;

	assign res_full = out_valid && (status == FULL);
	assign stall    = out_valid && !out_ready;

	`VTM_ASSERT_IMP(a_status_code, clk, arst_n, out_valid, status <= FULL, "bad status code")

	`VTM_ASSERT_IMP(a_full_index, clk, arst_n, res_full, node_index == '0, "full table index")

	// one request in flight at a time
	`VTM_ASSERT_NXT(a_one_request, clk, arst_n, in_valid && in_ready, !in_ready, "second request")

	`VTM_ASSERT_NXT(a_valid_hold, clk, arst_n, stall, out_valid, "stalled result dropped")

	`VTM_ASSERT_NXT(a_data_hold, clk, arst_n, stall, $stable({node_index, status}), "result moved")

endmodule

bind tolerance_vertex_merge_top vtm_checker u_vtm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (point.valid),
	.in_ready   (point.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.node_index (result.node_index),
	.status     (result.status)
);
